// File: rtl/core/crtq_pkg.sv
package crtq_pkg;

    // default request queue depth
    localparam int QUEUE_DEPTH_DEF = 4;

    // result queue between the decision logic and the m_ channel
    localparam int OQ_DEPTH = 4;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    // register reset values
    localparam logic [7:0] RST_READ_BLOCK_OP     = 8'd163;
    localparam logic [7:0] RST_QUERY_ADDRESS_OP  = 8'd176;
    localparam logic [7:0] RST_QUERY_MODE_OP     = 8'd177;
    localparam logic [7:0] RST_QUERY_BEEPER_OP   = 8'd178;
    localparam logic [7:0] RST_QUERY_AUTOREAD_OP = 8'd179;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_READ_BLOCK     = 3'd0,
        CFG_QUERY_ADDRESS  = 3'd1,
        CFG_QUERY_MODE     = 3'd2,
        CFG_QUERY_BEEPER   = 3'd3,
        CFG_QUERY_AUTOREAD = 3'd4
    } cfg_index_t;

    typedef enum logic [1:0] {
        REQ_SUBMIT     = 2'd0,
        REQ_RESPONSE   = 2'd1,
        REQ_LINK_ERROR = 2'd2,
        REQ_TICK       = 2'd3
    } req_type_t;

    typedef enum logic {
        KIND_READ  = 1'b0,
        KIND_QUERY = 1'b1
    } req_kind_t;

    typedef enum logic [1:0] {
        RES_ACK        = 2'd0,
        RES_COMPLETION = 2'd1,
        RES_ISSUE      = 2'd2,
        RES_RECOVERY   = 2'd3
    } result_kind_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BAD_PARAM  = 3'd1,
        ST_QUEUE_FULL = 3'd2,
        ST_CARD_ERROR = 3'd3,
        ST_LINK_ERROR = 3'd4,
        ST_TIMEOUT    = 3'd5
    } status_t;

    typedef struct packed {
        req_type_t   req_type;
        req_kind_t   request_kind;
        logic [7:0]  query_opcode;
        logic [7:0]  reader_address;
        logic [7:0]  block_number;
        logic        led_beep;
        logic [15:0] timeout_len;
        logic [31:0] request_tag;
        logic [7:0]  resp_opcode;
        logic [7:0]  resp_address;
        logic [7:0]  resp_reader_status;
        logic [31:0] now_ms;
    } in_item_t;

    typedef struct packed {
        result_kind_t result_kind;
        logic [31:0]  tag;
        status_t      result_status;
        logic [7:0]   reader_status;
        req_kind_t    issue_kind;
        logic [7:0]   issue_opcode;
        logic [7:0]   issue_address;
        logic [7:0]   issue_block;
        logic         issue_led_beep;
        logic         recover_link;
        logic         last;
    } out_item_t;

    // one queued request
    typedef struct packed {
        req_kind_t   kind;
        logic [7:0]  query_opcode;
        logic [7:0]  reader_address;
        logic [7:0]  block_number;
        logic        led_beep;
        logic [15:0] timeout_len;
        logic [31:0] tag;
    } req_entry_t;

    // request queue control
    typedef struct packed {
        logic push;
        logic pop;
    } fifo_ctrl_t;

endpackage

// File: rtl/core/crtq_req_fifo.sv
module crtq_req_fifo
    import crtq_pkg::*;
#(
    parameter int  QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  fifo_ctrl_t       ctrl,
    input  req_entry_t       push_entry,
    output req_entry_t       front,
    output logic [CNT_W-1:0] count
);

    req_entry_t       mem_reg [QUEUE_DEPTH];
    req_entry_t       front_reg;
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [PTR_W-1:0] head_inc, tail_inc;
    logic [CNT_W-1:0] count_reg, count_next;

    // wrapping pointer steps, next pointers and next count
    always_comb begin
        head_inc   = (head_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
        tail_inc   = (tail_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
        head_next  = ctrl.push ? head_inc : head_reg;
        tail_next  = ctrl.pop ? tail_inc : tail_reg;
        count_next = count_reg + CNT_W'(ctrl.push) - CNT_W'(ctrl.pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // storage write at head
    always_ff @(posedge aclk) begin
        if (ctrl.push) begin
            mem_reg[head_reg] <= push_entry;
        end
    end

    // front holds a copy of the oldest entry, bypassing a same-cycle write
    always_ff @(posedge aclk) begin
        if (ctrl.pop) begin
            if (count_reg == CNT_W'(1) && ctrl.push) begin
                front_reg <= push_entry;
            end else if (count_reg > CNT_W'(1)) begin
                front_reg <= mem_reg[tail_inc];
            end
        end else if (count_reg == '0 && ctrl.push) begin
            front_reg <= push_entry;
        end
    end

    assign front = front_reg;
    assign count = count_reg;

endmodule

// File: rtl/core/card_reader_transaction_queue_unit.sv
// Card reader transaction queue. Each s_ transfer is a submit, a response
// frame, a link error or a tick; the block checks and queues submits, runs
// one request at a time with a wrapping millisecond deadline, and emits up
// to two results per item on m_ (the last one marked by last). An item is
// decided in the cycle it is accepted. One item is taken per cycle while the
// four-entry result queue has room for two results, so the sustained rate
// is one item per cycle when each item yields one result and m_ready stays
// high, and the m_ side at one result per cycle bounds it otherwise. The
// request queue is QUEUE_DEPTH deep with its oldest entry held in a
// register; it needs no clearing after reset. Registers are to be written
// through cfg_wr_en/cfg_index/cfg_data only while the block is idle, which
// the block does not enforce; indexes beyond the list are ignored.
module card_reader_transaction_queue_unit
    import crtq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    // configuration registers
    logic [7:0] read_block_op_reg;
    logic [7:0] query_address_op_reg;
    logic [7:0] query_mode_op_reg;
    logic [7:0] query_beeper_op_reg;
    logic [7:0] query_autoread_op_reg;

    // active request
    logic       busy_reg;
    req_entry_t active_reg;
    logic [31:0] deadline_reg;

    // request queue
    fifo_ctrl_t       fifo_ctrl;
    req_entry_t       fifo_front;
    logic [CNT_W-1:0] fifo_count;

    // result queue
    out_item_t           oq_reg [OQ_DEPTH];
    logic [OQ_PTR_W-1:0] oq_rd_reg, oq_rd_next;
    logic [OQ_PTR_W-1:0] oq_wr_reg, oq_wr_next, oq_wr_second;
    logic [OQ_CNT_W-1:0] oq_count_reg, oq_count_next;

    // decision signals
    logic        in_fire, out_fire;
    logic        param_ok, query_known, resp_match;
    logic        push, pop, busy_mid;
    logic [31:0] elapsed;
    req_entry_t  entry, deq;
    out_item_t   r0, r1;
    logic        r0_v, r1_v;

    assign in_fire  = s_valid && s_ready;
    assign out_fire = m_valid && m_ready;
    assign s_ready  = oq_count_reg <= OQ_CNT_W'(OQ_DEPTH - 2);
    assign m_valid  = oq_count_reg != '0;
    assign m_data   = oq_reg[oq_rd_reg];

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            read_block_op_reg     <= RST_READ_BLOCK_OP;
            query_address_op_reg  <= RST_QUERY_ADDRESS_OP;
            query_mode_op_reg     <= RST_QUERY_MODE_OP;
            query_beeper_op_reg   <= RST_QUERY_BEEPER_OP;
            query_autoread_op_reg <= RST_QUERY_AUTOREAD_OP;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_READ_BLOCK:     read_block_op_reg     <= cfg_data;
                CFG_QUERY_ADDRESS:  query_address_op_reg  <= cfg_data;
                CFG_QUERY_MODE:     query_mode_op_reg     <= cfg_data;
                CFG_QUERY_BEEPER:   query_beeper_op_reg   <= cfg_data;
                CFG_QUERY_AUTOREAD: query_autoread_op_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // submit check, response match and deadline compare
    always_comb begin
        entry.kind           = s_data.request_kind;
        entry.query_opcode   = s_data.query_opcode;
        entry.reader_address = s_data.reader_address;
        entry.block_number   = s_data.block_number;
        entry.led_beep       = s_data.led_beep;
        entry.timeout_len    = s_data.timeout_len;
        entry.tag            = s_data.request_tag;

        query_known = s_data.query_opcode == query_address_op_reg
                   || s_data.query_opcode == query_mode_op_reg
                   || s_data.query_opcode == query_beeper_op_reg
                   || s_data.query_opcode == query_autoread_op_reg;
        param_ok = s_data.timeout_len != '0
                && (s_data.request_kind == KIND_READ || query_known);

        resp_match = (s_data.resp_opcode == ((active_reg.kind == KIND_QUERY)
                        ? active_reg.query_opcode : read_block_op_reg))
                  && ((active_reg.kind == KIND_QUERY
                        && active_reg.query_opcode == query_address_op_reg)
                      || s_data.resp_address == active_reg.reader_address);

        elapsed = s_data.now_ms - deadline_reg;
    end

    // results of one item: own event or timeout first, then an issue
    always_comb begin
        r0       = '0;
        r0_v     = 1'b0;
        push     = 1'b0;
        busy_mid = busy_reg;

        case (s_data.req_type)
            REQ_SUBMIT: begin
                r0_v           = 1'b1;
                r0.result_kind = RES_ACK;
                r0.tag         = s_data.request_tag;
                if (!param_ok) begin
                    r0.result_status = ST_BAD_PARAM;
                end else if (fifo_count == CNT_W'(QUEUE_DEPTH)) begin
                    r0.result_status = ST_QUEUE_FULL;
                end else begin
                    r0.result_status = ST_OK;
                    push             = 1'b1;
                end
            end
            REQ_RESPONSE: begin
                if (busy_reg && resp_match) begin
                    r0_v             = 1'b1;
                    r0.result_kind   = RES_COMPLETION;
                    r0.tag           = active_reg.tag;
                    r0.result_status = (s_data.resp_reader_status != '0)
                                       ? ST_CARD_ERROR : ST_OK;
                    r0.reader_status = s_data.resp_reader_status;
                    busy_mid         = 1'b0;
                end
            end
            REQ_LINK_ERROR: begin
                r0_v            = 1'b1;
                r0.recover_link = 1'b1;
                if (busy_reg) begin
                    r0.result_kind   = RES_COMPLETION;
                    r0.tag           = active_reg.tag;
                    r0.result_status = ST_LINK_ERROR;
                    busy_mid         = 1'b0;
                end else begin
                    r0.result_kind = RES_RECOVERY;
                end
            end
            default: ;
        endcase

        // deadline reached, not checked on submits
        if (s_data.req_type != REQ_SUBMIT && busy_mid && !elapsed[31]) begin
            r0_v             = 1'b1;
            r0.result_kind   = RES_COMPLETION;
            r0.tag           = active_reg.tag;
            r0.result_status = ST_TIMEOUT;
            r0.reader_status = '0;
            r0.recover_link  = 1'b1;
            busy_mid         = 1'b0;
        end

        // idle dequeue and issue
        pop  = !busy_mid && (fifo_count != '0 || push);
        deq  = (fifo_count == '0) ? entry : fifo_front;
        r1_v = pop;
        r1   = '0;
        r1.result_kind   = RES_ISSUE;
        r1.tag           = deq.tag;
        r1.result_status = ST_OK;
        r1.issue_kind    = deq.kind;
        r1.issue_address = deq.reader_address;
        if (deq.kind == KIND_QUERY) begin
            r1.issue_opcode = deq.query_opcode;
        end else begin
            r1.issue_block    = deq.block_number;
            r1.issue_led_beep = deq.led_beep;
        end

        // mark the final result of the item
        if (r1_v) begin
            r1.last = 1'b1;
        end else begin
            r0.last = 1'b1;
        end
    end

    // queue control for accepted items
    always_comb begin
        fifo_ctrl.push = in_fire && push;
        fifo_ctrl.pop  = in_fire && pop;
    end

    crtq_req_fifo #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_req_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (fifo_ctrl),
        .push_entry (entry),
        .front      (fifo_front),
        .count      (fifo_count)
    );

    // active request state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (in_fire) begin
            busy_reg <= busy_mid || pop;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire && pop) begin
            active_reg   <= deq;
            deadline_reg <= s_data.now_ms + 32'(deq.timeout_len);
        end
    end

    // result queue pointers
    always_comb begin
        oq_wr_second  = oq_wr_reg + OQ_PTR_W'(r0_v);
        oq_wr_next    = oq_wr_reg;
        oq_count_next = oq_count_reg - OQ_CNT_W'(out_fire);
        if (in_fire) begin
            oq_wr_next    = oq_wr_reg + OQ_PTR_W'(r0_v) + OQ_PTR_W'(r1_v);
            oq_count_next = oq_count_next + OQ_CNT_W'(r0_v) + OQ_CNT_W'(r1_v);
        end
        oq_rd_next = oq_rd_reg + OQ_PTR_W'(out_fire);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            oq_rd_reg    <= '0;
            oq_wr_reg    <= '0;
            oq_count_reg <= '0;
        end else begin
            oq_rd_reg    <= oq_rd_next;
            oq_wr_reg    <= oq_wr_next;
            oq_count_reg <= oq_count_next;
        end
    end

    // result queue entries
    always_ff @(posedge aclk) begin
        if (in_fire && r0_v) begin
            oq_reg[oq_wr_reg] <= r0;
        end
        if (in_fire && r1_v) begin
            oq_reg[oq_wr_second] <= r1;
        end
    end

    // with no active request the queue has been drained
    a_idle_queue_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !busy_reg |-> fifo_count == '0)
        else $error("requests waiting while no request is active");

    a_oq_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        oq_count_reg <= OQ_CNT_W'(OQ_DEPTH))
        else $error("result queue overflow");

    a_issue_sets_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        fifo_ctrl.pop |=> busy_reg)
        else $error("issued request not active");

endmodule
